// ===== rtl/lpbg_pkg.sv =====
// Shared types and constants for the LED pulse burst generator.
`timescale 1ns / 1ps

package lpbg_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned CountW  = 4;

  localparam logic [PeriodW-1:0] PERIOD_RESET = 16'd1000;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_LO_R = 8'h72;
  localparam logic [7:0] CHAR_UP_R = 8'h52;
  localparam logic [7:0] CHAR_LO_G = 8'h67;
  localparam logic [7:0] CHAR_UP_G = 8'h47;
  localparam logic [7:0] CHAR_LO_B = 8'h62;
  localparam logic [7:0] CHAR_UP_B = 8'h42;

  localparam logic [2:0] COL_NONE  = 3'b000;
  localparam logic [2:0] COL_RED   = 3'b001;
  localparam logic [2:0] COL_BLUE  = 3'b010;
  localparam logic [2:0] COL_GREEN = 3'b100;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_BURST   = 2'd1,
    MODE_HOLDOFF = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_FRONT = 2'd1,
    SEQ_DIV   = 2'd2,
    SEQ_STEP  = 2'd3
  } seq_e;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
  } lpbg_in_t;

  typedef struct packed {
    logic [2:0] led_pins;
    logic       char_taken;
  } lpbg_out_t;

endpackage

// ===== rtl/lpbg_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module lpbg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lpbg_pkg::PeriodW-1:0]  dividend_i,
  input  logic [lpbg_pkg::CountW-1:0]   divisor_i,
  output logic                          done_o,
  output logic [lpbg_pkg::PeriodW-1:0]  quot_o
);
  import lpbg_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic [CountW-1:0]   div_q, div_d;
  logic [PeriodW-1:0]  num_q, num_d;
  logic [CountW:0]     rem_sh;
  logic [CountW:0]     rem_sub;
  logic                ge;

  always_comb begin
    rem_sh  = {rem_q, num_q[PeriodW-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    ge      = (rem_sh >= {1'b0, div_q});
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    div_d   = div_q;
    num_d   = num_q;
    done_d  = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      num_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[CountW-1:0] : rem_sh[CountW-1:0];
      num_d = {num_q[PeriodW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {CountW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    num_q <= num_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider reports done while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == {CountW{1'b1}}) |=> done_q)
    else $error("divider finished its last step without done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (busy_q && cnt_q == '0))
    else $error("divider did not start on request");

endmodule

// ===== rtl/led_pulse_burst_generator.sv =====
// Top level of the LED pulse burst generator: tick sequencer and output register.
`timescale 1ns / 1ps

// Each input word is one timer tick, optionally carrying a command character.
// The input channel (in_valid_i/in_ready_o/in_data_i) takes one word at a
// time; every word yields exactly one output word (LED drive and a taken
// flag) on out_valid_o/out_ready_i/out_data_o, in order.
// A plain tick passes through the front and final steps, and its output word
// is registered as the input becomes ready again, so a new tick is taken only
// once the last one has loaded its output word. A tick that starts a burst also
// runs the bit-serial divider for period / N, 16 quotient steps, between the
// front and final steps and waits in the divide step until the divider reports
// done, holding the input until its output word is loaded.
// The output register holds its word until taken. While it is full a new
// tick is still accepted and processed up to its final step, which then
// waits for the register to drain.
// The period register is written through cfg_we_i/cfg_data_i.
// Reset sets the period to 1000 ticks, clears the colour and returns the
// block to idle with an empty output register.
module led_pulse_burst_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lpbg_pkg::lpbg_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lpbg_pkg::lpbg_out_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lpbg_pkg::PeriodW-1:0]  cfg_data_i
);
  import lpbg_pkg::*;

  seq_e                seq_q, seq_d;
  mode_e               mode_q, mode_d;
  logic [PeriodW-1:0]  period_q;
  logic [PeriodW-1:0]  tick_q, tick_d;
  logic [PeriodW-1:0]  spacing_q, spacing_d;
  logic [CountW-1:0]   pulses_q, pulses_d;
  logic [CountW-1:0]   blen_q, blen_d;
  logic [2:0]          colour_q, colour_d;
  logic                pin_q, pin_d;
  logic                taken_q, taken_d;
  lpbg_in_t            char_q, char_d;
  logic                out_valid_q, out_valid_d;
  lpbg_out_t           out_q, out_d;

  logic                div_start;
  logic                div_done;
  logic [PeriodW-1:0]  div_quot;
  logic [PeriodW-1:0]  tick_inc;
  logic [7:0]          digit;
  logic                is_digit;
  logic                out_free;

  lpbg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (period_q),
    .divisor_i  (blen_d),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    seq_d       = seq_q;
    mode_d      = mode_q;
    tick_d      = tick_q;
    spacing_d   = spacing_q;
    pulses_d    = pulses_q;
    blen_d      = blen_q;
    colour_d    = colour_q;
    pin_d       = pin_q;
    taken_d     = taken_q;
    char_d      = char_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    div_start   = 1'b0;
    tick_inc    = tick_q + 1'b1;
    digit       = char_q.char_code - CHAR_ZERO;
    is_digit    = (char_q.char_code >= CHAR_ONE) && (char_q.char_code <= CHAR_NINE);
    out_free    = !out_valid_q || out_ready_i;
    in_ready_o  = (seq_q == SEQ_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (seq_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          char_d = in_data_i;
          seq_d  = SEQ_FRONT;
        end
      end
      SEQ_FRONT: begin
        taken_d = 1'b0;
        seq_d   = SEQ_STEP;
        if (mode_q == MODE_HOLDOFF) begin
          tick_d = tick_inc;
          if (tick_inc == period_q) begin
            mode_d = MODE_IDLE;
          end
        end
        if (mode_d != MODE_BURST && mode_d != MODE_HOLDOFF) begin
          mode_d   = MODE_IDLE;
          tick_d   = '0;
          pulses_d = '0;
          if (char_q.char_valid) begin
            taken_d = 1'b1;
            if (is_digit) begin
              blen_d    = digit[CountW-1:0];
              mode_d    = MODE_BURST;
              div_start = 1'b1;
              seq_d     = SEQ_DIV;
            end else if (char_q.char_code == CHAR_LO_R || char_q.char_code == CHAR_UP_R) begin
              colour_d = COL_RED;
            end else if (char_q.char_code == CHAR_LO_G || char_q.char_code == CHAR_UP_G) begin
              colour_d = COL_GREEN;
            end else if (char_q.char_code == CHAR_LO_B || char_q.char_code == CHAR_UP_B) begin
              colour_d = COL_BLUE;
            end
          end
        end
      end
      SEQ_DIV: begin
        if (div_done) begin
          spacing_d = div_quot;
          seq_d     = SEQ_STEP;
        end
      end
      SEQ_STEP: begin
        if (out_free) begin
          if (mode_q == MODE_BURST) begin
            tick_d = tick_inc;
            if (tick_inc >= spacing_q) begin
              if (!pin_q) begin
                pin_d = 1'b1;
              end else begin
                pin_d    = 1'b0;
                pulses_d = pulses_q + 1'b1;
                tick_d   = '0;
              end
              if (pulses_d == blen_q) begin
                mode_d = MODE_HOLDOFF;
              end
            end
          end
          out_d.led_pins   = pin_d ? colour_q : COL_NONE;
          out_d.char_taken = taken_q;
          out_valid_d      = 1'b1;
          seq_d            = SEQ_IDLE;
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      mode_q      <= MODE_IDLE;
      tick_q      <= '0;
      spacing_q   <= '0;
      pulses_q    <= '0;
      blen_q      <= '0;
      colour_q    <= COL_NONE;
      pin_q       <= 1'b0;
      taken_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      mode_q      <= mode_d;
      tick_q      <= tick_d;
      spacing_q   <= spacing_d;
      pulses_q    <= pulses_d;
      blen_q      <= blen_d;
      colour_q    <= colour_d;
      pin_q       <= pin_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (seq_q == SEQ_DIV))
    else $error("divider result arrived outside the divide step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_BURST) |-> (blen_q != '0 && pulses_q <= blen_q))
    else $error("burst pulse count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_STEP && out_free) |=> (out_valid_o && seq_q == SEQ_IDLE))
    else $error("final step did not load the output register");

endmodule

// ===== tb/lpbg_checker.sv =====
// Checker for the LED pulse burst generator: predicts every LED word from the accepted ticks.
`timescale 1ns / 1ps

module lpbg_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  lpbg_pkg::lpbg_in_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  lpbg_pkg::lpbg_out_t           out_data_i,
  input  logic                          cfg_we_i,
  input  logic [lpbg_pkg::PeriodW-1:0]  cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   words_due_o,
  output int unsigned                   words_checked_o,
  output int unsigned                   bursts_started_o,
  output logic                          model_idle_o
);

  import lpbg_pkg::*;

  mode_e               mode;
  logic [PeriodW-1:0]  period;
  logic [PeriodW-1:0]  tick_cnt;
  logic [PeriodW-1:0]  spacing;
  logic [CountW-1:0]   pulses;
  logic [CountW-1:0]   burst_len;
  logic [2:0]          colour;
  logic                phase;
  lpbg_out_t           led_words_due [$];

  function automatic lpbg_out_t advance_tick(input lpbg_in_t word);
    lpbg_out_t res;
    res.char_taken = 1'b0;
    if (mode == MODE_HOLDOFF) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt == period) begin
        mode = MODE_IDLE;
      end
    end
    if (mode != MODE_BURST && mode != MODE_HOLDOFF) begin
      mode     = MODE_IDLE;
      tick_cnt = '0;
      pulses   = '0;
      if (word.char_valid) begin
        res.char_taken = 1'b1;
        if (word.char_code >= CHAR_ONE && word.char_code <= CHAR_NINE) begin
          burst_len = CountW'(word.char_code - CHAR_ZERO);
          spacing   = period / {{(PeriodW-CountW){1'b0}}, burst_len};
          mode      = MODE_BURST;
          bursts_started_o++;
        end else if (word.char_code == CHAR_LO_R || word.char_code == CHAR_UP_R) begin
          colour = COL_RED;
        end else if (word.char_code == CHAR_LO_G || word.char_code == CHAR_UP_G) begin
          colour = COL_GREEN;
        end else if (word.char_code == CHAR_LO_B || word.char_code == CHAR_UP_B) begin
          colour = COL_BLUE;
        end
      end
    end
    if (mode == MODE_BURST) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= spacing) begin
        if (!phase) begin
          phase = 1'b1;
        end else begin
          phase    = 1'b0;
          pulses   = pulses + 1'b1;
          tick_cnt = '0;
        end
        if (pulses == burst_len) begin
          mode = MODE_HOLDOFF;
        end
      end
    end
    res.led_pins = phase ? colour : COL_NONE;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lpbg_out_t due;
    if (!rst_ni) begin
      period    = PERIOD_RESET;
      mode      = MODE_IDLE;
      tick_cnt  = '0;
      spacing   = '0;
      pulses    = '0;
      burst_len = '0;
      colour    = COL_NONE;
      phase     = 1'b0;
      led_words_due.delete();
    end else begin
      if (cfg_we_i) begin
        period = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (led_words_due.size() == 0) begin
          $display("%0t: LED word with none expected: led_pins %0d, char_taken %0d",
                   $time, out_data_i.led_pins, out_data_i.char_taken);
          fail_count_o++;
        end else begin
          due = led_words_due.pop_front();
          words_checked_o++;
          if (out_data_i.led_pins !== due.led_pins) begin
            $display("%0t: led_pins expected %0d, got %0d",
                     $time, due.led_pins, out_data_i.led_pins);
            fail_count_o++;
          end
          if (out_data_i.char_taken !== due.char_taken) begin
            $display("%0t: char_taken expected %0d, got %0d",
                     $time, due.char_taken, out_data_i.char_taken);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        led_words_due.push_back(advance_tick(in_data_i));
      end
    end
    words_due_o  = led_words_due.size();
    model_idle_o = (mode == MODE_IDLE);
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the LED pulse burst generator: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;

  import lpbg_pkg::*;

  localparam int ClkHalf        = 2;
  localparam int ResetCycles    = 11;
  localparam int StallLimit     = 4000;
  localparam int LongHoldCycles = 400;
  localparam int SettleCycles   = 30;
  localparam int RandItems      = 190;
  localparam int FinalItems     = 120;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  lpbg_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lpbg_out_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [PeriodW-1:0]  cfg_data  = '0;

  int unsigned         fail_count;
  int unsigned         words_due;
  int unsigned         words_checked;
  int unsigned         bursts_started;
  logic                model_idle;

  int unsigned         hold_reqs = 0;
  int unsigned         ticks_sent = 0;
  int unsigned         periods_used = 0;
  int unsigned         quiet_cycles = 0;
  logic [PeriodW-1:0]  phase_periods [10];

  always #ClkHalf clk_i = ~clk_i;

  led_pulse_burst_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  lpbg_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .words_due_o      (words_due),
    .words_checked_o  (words_checked),
    .bursts_started_o (bursts_started),
    .model_idle_o     (model_idle)
  );

  // Every task below starts and returns at a falling edge.
  task automatic send_word(input logic valid_bit, input logic [7:0] code);
    in_valid <= 1'b1;
    in_data  <= {valid_bit, code};
    ticks_sent++;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Plain ticks run out any burst or hold-off; then every LED word is awaited.
  task automatic settle_block();
    while (!model_idle) send_word(1'b0, 8'($urandom));
    pause_sender(1);
    while (words_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_period(input logic [PeriodW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    periods_used++;
  endtask

  task automatic run_random_ticks(input int unsigned count);
    int unsigned run_left;
    lpbg_in_t    w;
    run_left = $urandom_range(1, 24);
    for (int n = 0; n < count; n++) begin
      w.char_valid = ($urandom_range(0, 9) >= 3);
      case ($urandom_range(0, 3))
        0: begin
          w.char_code = CHAR_ZERO + 8'($urandom_range(0, 9));
        end
        1: begin
          case ($urandom_range(0, 5))
            0:       w.char_code = CHAR_LO_R;
            1:       w.char_code = CHAR_UP_R;
            2:       w.char_code = CHAR_LO_G;
            3:       w.char_code = CHAR_UP_G;
            4:       w.char_code = CHAR_LO_B;
            default: w.char_code = CHAR_UP_B;
          endcase
        end
        default: begin
          w.char_code = 8'($urandom);
        end
      endcase
      send_word(w.char_valid, w.char_code);
      run_left--;
      if (run_left == 0) begin
        pause_sender($urandom_range(1, 8));
        run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      end
    end
  endtask

  initial begin : stimulus
    phase_periods = '{16'd2, 16'd5, 16'd9, 16'd16, 16'd40, 16'd1, 16'd7, 16'd100, 16'd3,
                      16'd12};
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // At the reset period only non-burst characters are offered.
    send_word(1'b1, CHAR_LO_G);
    send_word(1'b1, 8'h78);
    settle_block();
    write_period(16'd3);

    // A burst in the green colour chosen earlier, and a letter dropped while busy.
    send_word(1'b1, CHAR_ZERO + 8'd5);
    send_word(1'b1, CHAR_LO_R);
    settle_block();
    send_word(1'b1, CHAR_UP_R);
    send_word(1'b1, CHAR_LO_G);
    send_word(1'b1, CHAR_UP_G);
    send_word(1'b1, CHAR_LO_B);
    send_word(1'b1, CHAR_UP_B);
    send_word(1'b1, CHAR_ZERO);
    send_word(1'b1, 8'h00);
    send_word(1'b1, 8'hFF);
    send_word(1'b0, CHAR_ONE);
    send_word(1'b1, CHAR_LO_R);
    // Nine pulses with a period of three give a zero spacing.
    send_word(1'b1, CHAR_NINE);
    send_word(1'b1, CHAR_ONE);
    settle_block();
    send_word(1'b1, CHAR_LO_B);
    send_word(1'b1, CHAR_ZERO + 8'd3);
    settle_block();
    write_period(16'd1);
    send_word(1'b1, CHAR_UP_G);
    send_word(1'b1, CHAR_ONE);

    foreach (phase_periods[p]) begin
      settle_block();
      write_period(phase_periods[p]);
      if (p == 2) begin
        hold_reqs <= hold_reqs + 1;
      end
      run_random_ticks(RandItems);
    end

    // The widest period ends the run in the middle of a burst.
    settle_block();
    write_period(16'hFFFF);
    send_word(1'b1, CHAR_LO_B);
    send_word(1'b1, CHAR_NINE);
    run_random_ticks(FinalItems);

    pause_sender(1);
    while (words_due != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    $display("Sent %0d ticks over %0d period settings, from 1 to 65535 ticks.",
             ticks_sent, periods_used);
    $display("Checked %0d LED words; %0d bursts were started.", words_checked, bursts_started);
    if (fail_count == 0) begin
      $display("led_pulse_burst_generator regression: pass");
    end else begin
      $display("led_pulse_burst_generator regression: fail");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned hold_seen;
    int unsigned seg_left;
    int unsigned style;
    hold_seen = 0;
    seg_left  = 0;
    style     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 150);
          style    = $urandom_range(0, 2);
        end
        seg_left--;
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (seg_left % 4 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("led_pulse_burst_generator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
rtl/lpbg_pkg.sv
rtl/lpbg_div.sv
rtl/led_pulse_burst_generator.sv
tb/lpbg_checker.sv
tb/tb.sv
